[design/lss_pkg.sv]
// Shared types, constants and tables for the log spectrum smoother.
// Used by the controller, the datapath and the top module; depends on nothing.
package lss_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_MAX_BIN        = 2'd0;
  localparam logic [1:0] REG_SMOOTH_GAIN    = 2'd1;
  localparam logic [1:0] REG_AVERAGE_ENABLE = 2'd2;

  localparam logic [9:0]  MAX_BIN_RST = 10'd696;
  localparam logic [15:0] GAIN_RST    = 16'd13107;
  localparam logic        AVG_RST     = 1'b1;

  // Arithmetic constants (Q16 unless noted)
  localparam int unsigned LOG_OFFSET  = 1300005;  // 16 + log2(1/0.07)
  localparam logic [20:0] DB_SCALE    = 21'd908522;  // 20*ln2
  localparam logic [10:0] GROWTH_FRAC = 11'd1311;    // 1.02 minus one
  localparam logic [20:0] DIV10_RECIP = 21'd1677722; // 2^24 / 10, rounded up
  localparam logic [27:0] X_INIT      = 28'd196608;  // 3.0
  localparam logic [11:0] PREV_INIT   = 12'd3;

  localparam int MUL_W  = 21;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [2:0] NORM_LAST = 3'd4;
  localparam logic [2:0] TAP_LAST  = 3'd4;
  localparam logic [2:0] TAP_MID   = 3'd2;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_BINIT,
    ST_BUILD,
    ST_IDLE,
    ST_DISPATCH,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_SUM,
    ST_NORM,
    ST_INTERP,
    ST_FRAC,
    ST_SCALE,
    ST_LEVEL,
    ST_SM_OLD,
    ST_SM_NEW,
    ST_SM_WR,
    ST_RD_TAB,
    ST_RD_LVL,
    ST_RD_ACC,
    ST_DIV,
    ST_QUOT,
    ST_OUT
  } lss_state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RE,
    MUL_IM,
    MUL_INTERP,
    MUL_SCALE,
    MUL_SM_OLD,
    MUL_SM_NEW,
    MUL_DIV
  } lss_mul_e;

  typedef struct packed {
    logic       accept;
    logic       clear_step;
    logic       build_init;
    logic       build_step;
    lss_mul_e   mul_sel;
    logic       p_load;
    logic       norm_load;
    logic       norm_step;
    logic       frac_load;
    logic       lvl_load;
    logic       sm_load;
    logic       lvl_write;
    logic       lvl_from_tab;
    logic       tap_center;
    logic       tap_acc;
    logic       quot_load;
    logic       out_load;
    logic [2:0] step;
  } lss_cmd_t;

  typedef struct packed {
    logic is_read;
    logic ignore;
    logic in_range;
    logic avg;
    logic clear_last;
    logic build_stop;
    logic maxbin_wr;
    logic out_free;
  } lss_stat_t;

  // log2(1 + i/16) in Q16
  function automatic logic [16:0] log2_frac(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      5'd16:   v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

[design/lss_chan_if.sv]
// Handshake channels of the log spectrum smoother: requests, results, register writes.
// Stand-alone; no package needed.
interface lss_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [9:0]  position;
  logic [15:0] re_part;
  logic [15:0] im_part;
  modport source (output valid, action, position, re_part, im_part, input ready);
  modport sink   (input valid, action, position, re_part, im_part, output ready);
endinterface

interface lss_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] level;
  logic        entry_valid;
  logic [8:0]  entry_count;
  logic [9:0]  source_bin;
  modport source (output valid, level, entry_valid, entry_count, source_bin, input ready);
  modport sink   (input valid, level, entry_valid, entry_count, source_bin, output ready);
endinterface

interface lss_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [15:0] wdata;
  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

[design/lss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the level store and the log bin table.
module lss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/lss_ctrl.sv]
// Controller of the log spectrum smoother: sequences clearing, table build,
// sample updates and entry reads. Depends on lss_pkg.
module lss_ctrl import lss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  lss_stat_t stat_i,
  output lss_cmd_t  cmd_o
);

  lss_state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       rebuild_q, rebuild_d;
  logic       ready;

  assign ready       = (state_q == ST_IDLE) && !rebuild_q;
  assign req_ready_o = ready;

  // State, step counter and pending rebuild
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      step_q    <= '0;
      rebuild_q <= 1'b1;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      rebuild_q <= rebuild_d;
    end
  end

  assign rebuild_d = stat_i.maxbin_wr | (rebuild_q & (state_q != ST_BINIT));

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_CLEAR:    if (stat_i.clear_last) state_d = ST_BINIT;
      ST_BINIT:    state_d = ST_BUILD;
      ST_BUILD:    if (stat_i.build_stop) state_d = ST_IDLE;
      ST_IDLE: begin
        if (rebuild_q) state_d = ST_BINIT;
        else if (req_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        step_d = '0;
        if (stat_i.is_read) state_d = stat_i.in_range ? ST_RD_TAB : ST_OUT;
        else state_d = stat_i.ignore ? ST_IDLE : ST_SQ_RE;
      end
      ST_SQ_RE:    state_d = ST_SQ_IM;
      ST_SQ_IM:    state_d = ST_SUM;
      ST_SUM: begin
        step_d  = '0;
        state_d = ST_NORM;
      end
      ST_NORM: begin
        step_d = step_q + 3'd1;
        if (step_q == NORM_LAST) state_d = ST_INTERP;
      end
      ST_INTERP:   state_d = ST_FRAC;
      ST_FRAC:     state_d = ST_SCALE;
      ST_SCALE:    state_d = ST_LEVEL;
      ST_LEVEL:    state_d = ST_SM_OLD;
      ST_SM_OLD:   state_d = ST_SM_NEW;
      ST_SM_NEW:   state_d = ST_SM_WR;
      ST_SM_WR:    state_d = ST_IDLE;
      ST_RD_TAB:   state_d = ST_RD_LVL;
      ST_RD_LVL:   state_d = ST_RD_ACC;
      ST_RD_ACC: begin
        step_d = step_q + 3'd1;
        if (stat_i.avg && step_q != TAP_LAST) state_d = ST_RD_TAB;
        else state_d = stat_i.avg ? ST_DIV : ST_OUT;
      end
      ST_DIV:      state_d = ST_QUOT;
      ST_QUOT:     state_d = ST_OUT;
      ST_OUT:      if (stat_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_CLEAR;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o        = '0;
    cmd_o.step   = step_q;
    cmd_o.accept = ready && req_valid_i;
    case (state_q)
      ST_CLEAR:  cmd_o.clear_step = 1'b1;
      ST_BINIT:  cmd_o.build_init = 1'b1;
      ST_BUILD:  cmd_o.build_step = 1'b1;
      ST_SQ_RE:  cmd_o.mul_sel = MUL_RE;
      ST_SQ_IM: begin
        cmd_o.mul_sel = MUL_IM;
        cmd_o.p_load  = 1'b1;
      end
      ST_SUM:    cmd_o.norm_load = 1'b1;
      ST_NORM:   cmd_o.norm_step = 1'b1;
      ST_INTERP: cmd_o.mul_sel = MUL_INTERP;
      ST_FRAC:   cmd_o.frac_load = 1'b1;
      ST_SCALE:  cmd_o.mul_sel = MUL_SCALE;
      ST_LEVEL:  cmd_o.lvl_load = 1'b1;
      ST_SM_OLD: cmd_o.mul_sel = MUL_SM_OLD;
      ST_SM_NEW: begin
        cmd_o.mul_sel = MUL_SM_NEW;
        cmd_o.sm_load = 1'b1;
      end
      ST_SM_WR:  cmd_o.lvl_write = 1'b1;
      ST_RD_LVL: begin
        cmd_o.lvl_from_tab = 1'b1;
        cmd_o.tap_center   = !stat_i.avg || (step_q == TAP_MID);
      end
      ST_RD_ACC: cmd_o.tap_acc = 1'b1;
      ST_DIV:    cmd_o.mul_sel = MUL_DIV;
      ST_QUOT:   cmd_o.quot_load = 1'b1;
      ST_OUT:    cmd_o.out_load = stat_i.out_free;
      default:   cmd_o.step = step_q;
    endcase
  end

endmodule

[design/lss_dp.sv]
// Datapath of the log spectrum smoother: registers, shared multiplier, level
// store, log bin table and result register. Depends on lss_pkg and lss_ram.
module lss_dp import lss_pkg::*; #(
  parameter int BIN_COUNT   = 1024,
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lss_cmd_t    cmd_i,
  output lss_stat_t   stat_o,
  input  logic        req_action_i,
  input  logic [9:0]  req_position_i,
  input  logic [15:0] req_re_part_i,
  input  logic [15:0] req_im_part_i,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic [15:0] rsp_level_o,
  output logic        rsp_entry_valid_o,
  output logic [8:0]  rsp_entry_count_o,
  output logic [9:0]  rsp_source_bin_o
);

  localparam int BW = $clog2(BIN_COUNT);
  localparam int TW = $clog2(TABLE_DEPTH);

  // Configuration registers
  logic [9:0]  max_bin_q;
  logic [15:0] gain_q;
  logic        avg_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bin_q <= MAX_BIN_RST;
      gain_q    <= GAIN_RST;
      avg_en_q  <= AVG_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_MAX_BIN:        max_bin_q <= cfg_wdata_i[9:0];
        REG_SMOOTH_GAIN:    gain_q    <= cfg_wdata_i;
        REG_AVERAGE_ENABLE: avg_en_q  <= cfg_wdata_i[0];
        default:            max_bin_q <= max_bin_q;
      endcase
    end
  end

  // Request registers
  logic         action_q;
  logic [9:0]   pos_q;
  logic [15:0]  re_q, im_q;
  logic         inr_q, avg_q;
  logic [TW:0]  cnt_q;
  logic         inr_d, avg_d;

  assign inr_d = 32'(req_position_i) < 32'(cnt_q);
  assign avg_d = avg_en_q && (req_position_i >= 10'd2)
              && (32'(req_position_i) + 32'd2 < 32'(cnt_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= req_action_i;
      pos_q    <= req_position_i;
      re_q     <= req_re_part_i;
      im_q     <= req_im_part_i;
      inr_q    <= inr_d;
      avg_q    <= avg_d;
    end
  end

  // Shared multiplier with registered product
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_q;
  logic [15:0]       abs_re, abs_im;
  logic [31:0]       n_q, p_q;
  logic [4:0]        e_q;
  logic [16:0]       lo, hi;
  logic [23:0]       d_q;
  logic [15:0]       lvl_q;
  logic [19:0]       acc_q;
  logic [15:0]       s_rd;
  logic [9:0]        tab_rd;

  assign abs_re = re_q[15] ? (16'd0 - re_q) : re_q;
  assign abs_im = im_q[15] ? (16'd0 - im_q) : im_q;
  assign lo     = log2_frac({1'b0, n_q[30:27]});
  assign hi     = log2_frac({1'b0, n_q[30:27]} + 5'd1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_RE: begin
        mul_a = MUL_W'(abs_re);
        mul_b = MUL_W'(abs_re);
      end
      MUL_IM: begin
        mul_a = MUL_W'(abs_im);
        mul_b = MUL_W'(abs_im);
      end
      MUL_INTERP: begin
        mul_a = MUL_W'(hi - lo);
        mul_b = MUL_W'(n_q[26:15]);
      end
      MUL_SCALE: begin
        mul_a = MUL_W'(d_q[19:0]);
        mul_b = DB_SCALE;
      end
      MUL_SM_OLD: begin
        mul_a = MUL_W'(s_rd);
        mul_b = MUL_W'(17'h10000 - {1'b0, gain_q});
      end
      MUL_SM_NEW: begin
        mul_a = MUL_W'(lvl_q);
        mul_b = MUL_W'(gain_q);
      end
      MUL_DIV: begin
        mul_a = MUL_W'(acc_q + 20'd5);
        mul_b = DIV10_RECIP;
      end
      default: mul_a = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Power, leading-one normalisation and dB level
  logic [25:0]       interp_rnd;
  logic [16:0]       frac;
  logic signed [23:0] d_d;
  logic [PROD_W-1:0] v_rnd;
  logic [15:0]       lvl_d;

  assign interp_rnd = prod_q[25:0] + 26'd2048;
  assign frac       = lo + 17'(interp_rnd[25:12]);
  assign d_d        = $signed({3'b000, e_q, 16'h0000}) + $signed(24'(frac))
                    - $signed(24'(LOG_OFFSET));
  assign v_rnd      = prod_q + PROD_W'(24'h800000);

  always_comb begin
    if (d_q[23] || d_q == '0) lvl_d = '0;
    else if (v_rnd[PROD_W-1:40] != '0) lvl_d = 16'hFFFF;
    else lvl_d = v_rnd[39:24];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.p_load) p_q <= prod_q[31:0];
    if (cmd_i.norm_load) begin
      n_q <= p_q + prod_q[31:0];
      e_q <= 5'd31;
    end else if (cmd_i.norm_step) begin
      // Binary search for the leading one: 16, 8, 4, 2, then 1 place
      case (cmd_i.step)
        3'd0: if (n_q[31:16] == '0) begin
          n_q <= {n_q[15:0], 16'h0000};
          e_q <= e_q - 5'd16;
        end
        3'd1: if (n_q[31:24] == '0) begin
          n_q <= {n_q[23:0], 8'h00};
          e_q <= e_q - 5'd8;
        end
        3'd2: if (n_q[31:28] == '0) begin
          n_q <= {n_q[27:0], 4'h0};
          e_q <= e_q - 5'd4;
        end
        3'd3: if (n_q[31:30] == '0) begin
          n_q <= {n_q[29:0], 2'b00};
          e_q <= e_q - 5'd2;
        end
        default: if (!n_q[31]) begin
          n_q <= {n_q[30:0], 1'b0};
          e_q <= e_q - 5'd1;
        end
      endcase
    end
    if (cmd_i.frac_load) d_q <= d_d;
    if (cmd_i.lvl_load) lvl_q <= lvl_d;
  end

  // Smoothing accumulate
  logic [PROD_W-1:0] sm_q;
  logic [PROD_W-1:0] sm_sum;
  assign sm_sum = sm_q + prod_q + PROD_W'(17'h08000);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sm_load) sm_q <= prod_q;
  end

  // Clearing pass counter
  logic [BW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clear_step) clr_q <= clr_q + BW'(1);
  end

  // Level store
  logic          lvl_we;
  logic [BW-1:0] lvl_waddr, lvl_raddr;
  logic [15:0]   lvl_wdata;

  assign lvl_we    = cmd_i.clear_step | cmd_i.lvl_write;
  assign lvl_waddr = cmd_i.clear_step ? clr_q : BW'(pos_q);
  assign lvl_wdata = cmd_i.clear_step ? 16'h0000 : sm_sum[31:16];
  assign lvl_raddr = cmd_i.lvl_from_tab ? BW'(tab_rd) : BW'(pos_q);

  lss_ram #(.WIDTH(16), .DEPTH(BIN_COUNT)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .raddr_i (lvl_raddr),
    .rdata_o (s_rd)
  );

  // Log bin table build: x grows by 1.02 each step in Q16
  logic [27:0]  x_q;
  logic [11:0]  prev_q;
  logic [38:0]  grow;
  logic [27:0]  xn;
  logic [11:0]  f;
  logic         build_stop;
  logic         tab_we;
  logic [TW-1:0] taddr_q;

  assign grow = x_q * GROWTH_FRAC + 39'd32768;
  assign xn   = x_q + 28'(grow[38:16]);
  assign f    = xn[27:16];
  assign build_stop = (32'(f) > 32'(max_bin_q)) || (32'(f) >= BIN_COUNT)
                   || (32'(cnt_q) >= TABLE_DEPTH);
  assign tab_we = cmd_i.build_step && !build_stop && (f != prev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.build_init) begin
      cnt_q <= '0;
    end else if (tab_we) begin
      cnt_q <= cnt_q + (TW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_init) begin
      x_q    <= X_INIT;
      prev_q <= PREV_INIT;
    end else if (cmd_i.build_step && !build_stop) begin
      x_q    <= xn;
      prev_q <= f;
    end
  end

  lss_ram #(.WIDTH(10), .DEPTH(TABLE_DEPTH)) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (cnt_q[TW-1:0]),
    .wdata_i (f[9:0]),
    .raddr_i (taddr_q),
    .rdata_o (tab_rd)
  );

  // Entry read: walk the taps, weight 1/2/4/2/1 when averaging
  logic [15:0] quot_q;
  logic [9:0]  src_q;
  logic [19:0] tap_val;

  always_comb begin
    tap_val = 20'(s_rd);
    if (avg_q) begin
      case (cmd_i.step)
        3'd1, 3'd3: tap_val = 20'(s_rd) << 1;
        3'd2:       tap_val = 20'(s_rd) << 2;
        default:    tap_val = 20'(s_rd);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      taddr_q <= avg_d ? (TW'(req_position_i) - TW'(2)) : TW'(req_position_i);
      acc_q   <= '0;
    end else if (cmd_i.tap_acc) begin
      taddr_q <= taddr_q + TW'(1);
      acc_q   <= acc_q + tap_val;
    end
    if (cmd_i.tap_center) src_q <= tab_rd;
    if (cmd_i.quot_load) quot_q <= prod_q[39:24];
  end

  // Result register
  logic        out_valid_q;
  logic [15:0] out_level_q;
  logic        out_ev_q;
  logic [8:0]  out_cnt_q;
  logic [9:0]  out_bin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (rsp_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_level_q <= !inr_q ? 16'h0000 : (avg_q ? quot_q : acc_q[15:0]);
      out_ev_q    <= inr_q;
      out_cnt_q   <= 9'(cnt_q);
      out_bin_q   <= inr_q ? src_q : 10'd0;
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_level_o       = out_level_q;
  assign rsp_entry_valid_o = out_ev_q;
  assign rsp_entry_count_o = out_cnt_q;
  assign rsp_source_bin_o  = out_bin_q;

  // Status to the controller
  assign stat_o.is_read    = action_q;
  assign stat_o.ignore     = (pos_q == 10'd0) || (32'(pos_q) >= BIN_COUNT);
  assign stat_o.in_range   = inr_q;
  assign stat_o.avg        = avg_q;
  assign stat_o.clear_last = clr_q == BW'(BIN_COUNT - 1);
  assign stat_o.build_stop = build_stop;
  assign stat_o.maxbin_wr  = cfg_valid_i && (cfg_addr_i == REG_MAX_BIN);
  assign stat_o.out_free   = !out_valid_q || rsp_ready_i;

endmodule

[design/log_spectrum_smoother_unit.sv]
// Log spectrum smoother. A bin sample passes through one shared multiplier
// and a five-step leading-one search; a read is a copy or, with averaging,
// a five-tap average, each tap read through the table and level RAMs.
// One request at a time; a result waits in the output register.
// After reset the level store is cleared bin by bin, then the log bin table
// is built; a max_bin write rebuilds the table.
module log_spectrum_smoother_unit import lss_pkg::*; #(
  parameter int BIN_COUNT   = 1024,
  parameter int TABLE_DEPTH = 256
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  lss_req_if.sink   req_i,
  lss_rsp_if.source rsp_o,
  lss_cfg_if.sink   cfg_i
);

  lss_cmd_t  cmd;
  lss_stat_t stat;

  assign cfg_i.ready = 1'b1;

  lss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lss_dp #(.BIN_COUNT(BIN_COUNT), .TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_action_i      (req_i.action),
    .req_position_i    (req_i.position),
    .req_re_part_i     (req_i.re_part),
    .req_im_part_i     (req_i.im_part),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_addr_i        (cfg_i.addr),
    .cfg_wdata_i       (cfg_i.wdata),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_level_o       (rsp_o.level),
    .rsp_entry_valid_o (rsp_o.entry_valid),
    .rsp_entry_count_o (rsp_o.entry_count),
    .rsp_source_bin_o  (rsp_o.source_bin)
  );

endmodule
